// ----- rtl/core/lcgh_pkg.sv -----
// ----------------------------------------------------------------------------
// lcgh_pkg
// shared types, constants and the arctangent table for the clearance gate
// ----------------------------------------------------------------------------
package lcgh_pkg;

    localparam int CordicW     = 44;
    localparam int CordicSteps = 14;

    localparam logic [15:0] InvGain      = 16'd19899;
    localparam logic [17:0] HalfErrScale = 18'd201062;
    localparam logic [7:0]  ForwardSpeed = 8'd200;
    localparam logic [16:0] MaxScanPoints = 17'd4096;

    typedef enum logic [2:0] {
        OP_ARM    = 3'd0,
        OP_DISARM = 3'd1,
        OP_POINT  = 3'd2,
        OP_END    = 3'd3,
        OP_TICK   = 3'd4
    } t_opcode;

    localparam logic [2:0] CFG_START  = 3'd0;
    localparam logic [2:0] CFG_STEP   = 3'd1;
    localparam logic [2:0] CFG_LEN    = 3'd2;
    localparam logic [2:0] CFG_HW     = 3'd3;
    localparam logic [2:0] CFG_CPL    = 3'd4;
    localparam logic [2:0] CFG_CFL    = 3'd5;
    localparam logic [2:0] CFG_RAD    = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_ROT,
        ST_BOX,
        ST_SQ,
        ST_ARR,
        ST_QUAT,
        ST_AT1_GO,
        ST_AT1,
        ST_AT2_GO,
        ST_AT2,
        ST_ERR,
        ST_RES,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic vect;
    } t_cordic_cmd;

    function automatic logic [13:0] atan_val(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/lcgh_cordic.sv -----
// ----------------------------------------------------------------------------
// lcgh_cordic
// iterative cordic, one micro-rotation per cycle, rotation or vectoring
// ----------------------------------------------------------------------------
module lcgh_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lcgh_pkg::t_cordic_cmd             i_cmd,
    input  logic signed [lcgh_pkg::CordicW-1:0] i_x,
    input  logic signed [lcgh_pkg::CordicW-1:0] i_y,
    input  logic signed [17:0]                i_z,
    output logic                              o_done,
    output logic signed [lcgh_pkg::CordicW-1:0] o_x,
    output logic signed [lcgh_pkg::CordicW-1:0] o_y,
    output logic signed [17:0]                o_z
);
    import lcgh_pkg::*;

    logic signed [CordicW-1:0] r_x, r_y, xs, ys;
    logic signed [17:0]        r_z, a;
    logic [3:0]                r_i;
    logic                      r_busy, r_vect, r_done;
    logic                      hold, pos;

    always_comb begin
        xs   = r_x >>> r_i;
        ys   = r_y >>> r_i;
        a    = $signed({4'b0, atan_val(r_i)});
        hold = r_vect && (r_y == '0);
        pos  = r_vect ? r_y[CordicW-1] : !r_z[17];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_vect <= i_cmd.vect;
                // vectoring: a vector in the left half plane is turned by pi first
                if (i_cmd.vect && i_x[CordicW-1]) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= 18'sd32768;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= i_cmd.vect ? 18'sd0 : i_z;
                end
            end else if (r_busy) begin
                if (!hold) begin
                    if (pos) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - a;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + a;
                    end
                end
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CordicSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ----- rtl/core/lidar_clear_gate_heading_drive_core.sv -----
// ----------------------------------------------------------------------------
// lidar_clear_gate_heading_drive_core
// lidar box clearance gate and heading drive with a shared serial datapath
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | i_valid / o_stall    | opcode, range, target/robot pose, quat
//  output   | o_valid / i_stall    | linear_mm_s, angular_mrad_s, finished
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data (16 bit)
//
//  arm, disarm and scan end are handled in the idle state
//  a scan point runs 16 bit-serial multiply steps for the sample angle and
//  the gain-scaled range, then 14 cordic rotation steps
//  a moving tick runs 48 serial steps for the squared distance and, short
//  of arrival, 4 quaternion products and two 14 step cordic atan2 passes
//  one item at a time; o_stall is high while an item is in flight or its
//  result waits for the output register; reset is synchronous, active low
// ----------------------------------------------------------------------------
module lidar_clear_gate_heading_drive_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic [15:0]        i_range_mm,
    input  logic signed [23:0] i_target_x_mm,
    input  logic signed [23:0] i_target_y_mm,
    input  logic signed [23:0] i_robot_x_mm,
    input  logic signed [23:0] i_robot_y_mm,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_linear_mm_s,
    output logic signed [11:0] o_angular_mrad_s,
    output logic               o_finished,
    // config port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import lcgh_pkg::*;

    t_state r_state, n_state;

    // configuration registers
    logic [15:0] r_start_ang, r_step, r_len, r_hw, r_cpl, r_cfl, r_rad;

    // gate state
    logic        r_armed, n_armed, r_move, n_move;
    logic [15:0] r_frames, n_frames, r_points, n_points, r_idx, n_idx;

    // serial multiplier shift registers
    logic [47:0] r_mc, n_mc;
    logic [23:0] r_mp, n_mp;
    logic [48:0] r_acc, n_acc;
    logic [15:0] r_mc2, n_mc2, r_acc2, n_acc2;
    logic [5:0]  r_cnt, n_cnt;

    // tick operands and intermediates
    logic signed [24:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [15:0] r_qx, n_qx, r_qy, n_qy, r_qz, n_qz, r_qw, n_qw;
    logic signed [32:0] r_num, n_num;
    logic [32:0]        r_sq, n_sq;
    logic [15:0]        r_theta, n_theta;
    logic signed [15:0] r_err, n_err;
    logic signed [34:0] r_prod, n_prod;

    // staged and registered result
    logic [7:0]         r_res_lin, n_res_lin;
    logic [11:0]        r_res_ang, n_res_ang;
    logic               r_res_fin, n_res_fin;
    logic               r_ovalid, n_ovalid;
    logic [7:0]         r_olin, n_olin;
    logic [11:0]        r_oang, n_oang;
    logic               r_ofin, n_ofin;

    // cordic
    t_cordic_cmd               c_cmd;
    logic signed [CordicW-1:0] c_xi, c_yi, c_xo, c_yo;
    logic signed [17:0]        c_zi, c_zo;
    logic                      c_done;

    // helpers
    logic                      accept, out_free;
    logic signed [24:0]        dx_in, dy_in;
    logic [15:0]               ang;
    logic signed [17:0]        zf;
    logic signed [CordicW-1:0] xf, ay;
    logic signed [15:0]        qa, qb;
    logic signed [31:0]        qp;
    logic [31:0]               rad_sq;
    logic                      in_box;
    logic signed [34:0]        rnd;

    lcgh_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (c_cmd),
        .i_x     (c_xi),
        .i_y     (c_yi),
        .i_z     (c_zi),
        .o_done  (c_done),
        .o_x     (c_xo),
        .o_y     (c_yo),
        .o_z     (c_zo)
    );

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    assign dx_in = 25'(i_target_x_mm) - 25'(i_robot_x_mm);
    assign dy_in = 25'(i_target_y_mm) - 25'(i_robot_y_mm);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_POINT && r_armed && ({1'b0, r_idx} < MaxScanPoints)) begin
                        n_state = ST_MUL;
                    end else if (i_opcode == OP_TICK && r_armed) begin
                        n_state = r_move ? ST_SQ : ST_OUT;
                    end
                end
            end
            ST_MUL:    n_state = (r_cnt == 6'd15) ? ST_FOLD : ST_MUL;
            ST_FOLD:   n_state = ST_ROT;
            ST_ROT:    n_state = c_done ? ST_BOX : ST_ROT;
            ST_BOX:    n_state = ST_IDLE;
            ST_SQ:     n_state = (r_cnt == 6'd47) ? ST_ARR : ST_SQ;
            ST_ARR:    n_state = ({17'b0, rad_sq} > r_acc) ? ST_OUT : ST_QUAT;
            ST_QUAT:   n_state = (r_cnt == 6'd3) ? ST_AT1_GO : ST_QUAT;
            ST_AT1_GO: n_state = ST_AT1;
            ST_AT1:    n_state = c_done ? ST_AT2_GO : ST_AT1;
            ST_AT2_GO: n_state = ST_AT2;
            ST_AT2:    n_state = c_done ? ST_ERR : ST_AT2;
            ST_ERR:    n_state = ST_RES;
            ST_RES:    n_state = ST_OUT;
            ST_OUT:    n_state = out_free ? ST_IDLE : ST_OUT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_armed   = r_armed;
        n_move    = r_move;
        n_frames  = r_frames;
        n_points  = r_points;
        n_idx     = r_idx;
        n_mc      = r_mc;
        n_mp      = r_mp;
        n_acc     = r_acc;
        n_mc2     = r_mc2;
        n_acc2    = r_acc2;
        n_cnt     = r_cnt;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_qx      = r_qx;
        n_qy      = r_qy;
        n_qz      = r_qz;
        n_qw      = r_qw;
        n_num     = r_num;
        n_sq      = r_sq;
        n_theta   = r_theta;
        n_err     = r_err;
        n_prod    = r_prod;
        n_res_lin = r_res_lin;
        n_res_ang = r_res_ang;
        n_res_fin = r_res_fin;
        n_ovalid  = r_ovalid && i_stall;
        n_olin    = r_olin;
        n_oang    = r_oang;
        n_ofin    = r_ofin;
        c_cmd     = '0;
        c_xi      = '0;
        c_yi      = '0;
        c_zi      = '0;
        ang       = r_start_ang + r_acc2;
        zf        = 18'(signed'(ang));
        xf        = 44'(signed'({1'b0, r_acc[31:0]}));
        ay        = c_yo[CordicW-1] ? -c_yo : c_yo;
        in_box    = (ay < $signed({13'b0, r_hw, 15'b0})) && !c_xo[CordicW-1]
                    && (c_xo <= $signed({13'b0, r_len, 15'b0}));
        qa        = r_qw;
        qb        = r_qz;
        case (r_cnt[1:0])
            2'd0:    begin qa = r_qw; qb = r_qz; end
            2'd1:    begin qa = r_qx; qb = r_qy; end
            2'd2:    begin qa = r_qy; qb = r_qy; end
            default: begin qa = r_qz; qb = r_qz; end
        endcase
        qp        = qa * qb;
        rad_sq    = r_rad * r_rad;
        rnd       = (r_prod + 35'sd2097152) >>> 22;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_ARM: begin
                            if (!r_armed) begin
                                n_points = '0;
                                n_idx    = '0;
                            end
                            n_armed = 1'b1;
                        end
                        OP_DISARM: begin
                            n_armed  = 1'b0;
                            n_move   = 1'b0;
                            n_points = '0;
                            n_idx    = '0;
                        end
                        OP_POINT: begin
                            // serial multiply: index * step and range * inverse gain
                            n_mp   = {8'b0, r_idx};
                            n_mc2  = r_step;
                            n_acc2 = '0;
                            n_mc   = {32'b0, i_range_mm};
                            n_acc  = '0;
                            n_cnt  = '0;
                            if (r_armed && ({1'b0, r_idx} < MaxScanPoints)) begin
                                n_idx = r_idx + 16'd1;
                            end
                        end
                        OP_END: begin
                            if (r_armed) begin
                                if (r_points < r_cpl) begin
                                    if (r_frames != 16'hFFFF) begin
                                        n_frames = r_frames + 16'd1;
                                    end
                                    if (n_frames > r_cfl) begin
                                        n_move = 1'b1;
                                    end
                                end else begin
                                    n_move   = 1'b0;
                                    n_frames = '0;
                                end
                            end
                            n_points = '0;
                            n_idx    = '0;
                        end
                        OP_TICK: begin
                            n_res_lin = '0;
                            n_res_ang = '0;
                            n_res_fin = 1'b0;
                            n_dx      = dx_in;
                            n_dy      = dy_in;
                            n_qx      = i_quat_x;
                            n_qy      = i_quat_y;
                            n_qz      = i_quat_z;
                            n_qw      = i_quat_w;
                            // squared distance runs on the magnitudes
                            n_mp      = dx_in[24] ? 24'(-dx_in) : dx_in[23:0];
                            n_mc      = {24'b0, n_mp};
                            n_acc     = '0;
                            n_cnt     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                n_acc2 = r_acc2 + (r_mp[0] ? r_mc2 : 16'd0);
                n_mc2  = r_mc2 << 1;
                n_mp   = r_mp >> 1;
                n_acc  = r_acc + (InvGain[r_cnt[3:0]] ? {1'b0, r_mc} : 49'd0);
                n_mc   = r_mc << 1;
                n_cnt  = r_cnt + 6'd1;
            end
            ST_FOLD: begin
                // fold into the right half plane, negating the start vector
                if (zf > 18'sd16384) begin
                    zf = zf - 18'sd32768;
                    xf = -xf;
                end else if (zf < -18'sd16384) begin
                    zf = zf + 18'sd32768;
                    xf = -xf;
                end
                c_cmd.start = 1'b1;
                c_cmd.vect  = 1'b0;
                c_xi        = xf;
                c_zi        = zf;
            end
            ST_BOX: begin
                if (in_box && r_points != 16'hFFFF) begin
                    n_points = r_points + 16'd1;
                end
            end
            ST_SQ: begin
                n_acc = r_acc + (r_mp[0] ? {1'b0, r_mc} : 49'd0);
                if (r_cnt == 6'd23) begin
                    n_mp = r_dy[24] ? 24'(-r_dy) : r_dy[23:0];
                    n_mc = {24'b0, n_mp};
                end else begin
                    n_mp = r_mp >> 1;
                    n_mc = r_mc << 1;
                end
                n_cnt = r_cnt + 6'd1;
            end
            ST_ARR: begin
                n_cnt = '0;
                n_num = '0;
                n_sq  = '0;
                if ({17'b0, rad_sq} > r_acc) begin
                    n_res_fin = 1'b1;
                    n_armed   = 1'b0;
                    n_move    = 1'b0;
                end
            end
            ST_QUAT: begin
                if (r_cnt[1]) begin
                    n_sq = r_sq + 33'(unsigned'(qp));
                end else begin
                    n_num = r_num + 33'(qp);
                end
                n_cnt = r_cnt + 6'd1;
            end
            ST_AT1_GO: begin
                c_cmd.start = 1'b1;
                c_cmd.vect  = 1'b1;
                c_xi        = {{3{r_dx[24]}}, r_dx, 16'b0};
                c_yi        = {{3{r_dy[24]}}, r_dy, 16'b0};
            end
            ST_AT1: begin
                if (c_done) begin
                    n_theta = c_zo[15:0];
                end
            end
            ST_AT2_GO: begin
                c_cmd.start = 1'b1;
                c_cmd.vect  = 1'b1;
                c_xi        = 44'sd1073741824 - $signed({10'b0, r_sq, 1'b0});
                c_yi        = {{10{r_num[32]}}, r_num, 1'b0};
            end
            ST_AT2: begin
                if (c_done) begin
                    n_err = r_theta - c_zo[15:0];
                end
            end
            ST_ERR: begin
                n_prod = r_err * $signed({1'b0, HalfErrScale});
            end
            ST_RES: begin
                n_res_lin = ForwardSpeed;
                n_res_ang = rnd[11:0];
            end
            ST_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olin   = r_res_lin;
                    n_oang   = r_res_ang;
                    n_ofin   = r_res_fin;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_armed  <= 1'b0;
            r_move   <= 1'b0;
            r_frames <= '0;
            r_points <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_armed  <= n_armed;
            r_move   <= n_move;
            r_frames <= n_frames;
            r_points <= n_points;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mc      <= n_mc;
        r_mp      <= n_mp;
        r_acc     <= n_acc;
        r_mc2     <= n_mc2;
        r_acc2    <= n_acc2;
        r_cnt     <= n_cnt;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_qz      <= n_qz;
        r_qw      <= n_qw;
        r_num     <= n_num;
        r_sq      <= n_sq;
        r_theta   <= n_theta;
        r_err     <= n_err;
        r_prod    <= n_prod;
        r_res_lin <= n_res_lin;
        r_res_ang <= n_res_ang;
        r_res_fin <= n_res_fin;
        r_olin    <= n_olin;
        r_oang    <= n_oang;
        r_ofin    <= n_ofin;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_ang <= 16'h8000;
            r_step      <= 16'd91;
            r_len       <= 16'd1000;
            r_hw        <= 16'd300;
            r_cpl       <= 16'd10;
            r_cfl       <= 16'd10;
            r_rad       <= 16'd300;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START: r_start_ang <= i_cfg_data;
                CFG_STEP:  r_step      <= i_cfg_data;
                CFG_LEN:   r_len       <= i_cfg_data;
                CFG_HW:    r_hw        <= i_cfg_data;
                CFG_CPL:   r_cpl       <= i_cfg_data;
                CFG_CFL:   r_cfl       <= i_cfg_data;
                CFG_RAD:   r_rad       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_linear_mm_s    = r_olin;
    assign o_angular_mrad_s = r_oang;
    assign o_finished       = r_ofin;

endmodule
